// ===== sv/fpfa_pkg.sv =====
// Shared types, codes and defaults for the fixed-partition fit allocator.
package fpfa_pkg;

    localparam int MAX_PARTITIONS_DEF = 16;
    localparam int SIZE_BITS_DEF      = 16;
    localparam int ID_BITS_DEF        = 8;

    localparam int OPCODE_W  = 2;
    localparam int SLOT_W    = 4;
    localparam int SIZE_W    = 16;
    localparam int PID_W     = 8;
    localparam int POLICY_W  = 2;
    localparam int PIU_W     = 5;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [PIU_W-1:0]    PIU_RESET    = 5'd16;
    localparam logic [POLICY_W-1:0] POLICY_RESET = 2'd0;

    // Item opcodes
    localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_FREE  = 2'd2;

    // Fit policies; the unused code acts as first fit
    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd1;
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd2;

    // Register select, taken from paddr[2]
    localparam logic REG_FIT_POLICY = 1'b0;
    localparam logic REG_PIU        = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic latch;   // capture item, reset scan
        logic scan;    // issue next table read
        logic commit;  // apply item, present result
    } t_ctrl_cmd;

    typedef struct packed {
        logic alloc_none;  // no slots take part
        logic scan_last;   // current read is the last slot
    } t_ctrl_status;

endpackage

// ===== sv/fpfa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module fpfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/fpfa_ctrl.sv =====
// Sequencer for the allocator: accept, table scan, drain, commit.
module fpfa_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [fpfa_pkg::OPCODE_W-1:0] i_opcode,
    input  fpfa_pkg::t_ctrl_status        i_status,
    output fpfa_pkg::t_ctrl_cmd           o_cmd,
    output logic                          o_busy
);
    import fpfa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    if (i_opcode == OP_ALLOC && !i_status.alloc_none) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last read data is compared this cycle
                n_state = ST_DONE;
            end
            ST_DONE: begin
                o_cmd.commit = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/fpfa_dp.sv =====
// Allocator datapath: item registers, size table, busy bits, fit compare, result.
module fpfa_dp #(
    parameter int MAX_PARTITIONS = fpfa_pkg::MAX_PARTITIONS_DEF,
    parameter int SIZE_BITS      = fpfa_pkg::SIZE_BITS_DEF,
    parameter int ID_BITS        = fpfa_pkg::ID_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fpfa_pkg::t_ctrl_cmd           i_cmd,
    output fpfa_pkg::t_ctrl_status        o_status,
    input  logic [fpfa_pkg::POLICY_W-1:0] i_policy,
    input  logic [fpfa_pkg::PIU_W-1:0]    i_piu,
    input  logic [fpfa_pkg::OPCODE_W-1:0] i_opcode,
    input  logic [fpfa_pkg::SLOT_W-1:0]   i_slot_index,
    input  logic [fpfa_pkg::SIZE_W-1:0]   i_size_value,
    input  logic [fpfa_pkg::PID_W-1:0]    i_process_id,
    output logic                          o_done,
    output logic                          o_granted,
    output logic [fpfa_pkg::SLOT_W-1:0]   o_chosen_slot,
    output logic [fpfa_pkg::PID_W-1:0]    o_owner_echo
);
    import fpfa_pkg::*;

    localparam int IDX_W = $clog2(MAX_PARTITIONS);
    localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);

    // latched item
    logic [OPCODE_W-1:0]  r_op;
    logic [IDX_W-1:0]     r_slot;
    logic                 r_load_ok;
    logic [SIZE_BITS-1:0] r_req;
    logic [ID_BITS-1:0]   r_pid;

    // scan
    logic [IDX_W-1:0]          r_k;
    logic                      r_cmp_v;
    logic [IDX_W-1:0]          r_cmp_idx;
    logic                      r_found;
    logic [IDX_W-1:0]          r_pick;
    logic [SIZE_BITS-1:0]      r_pick_left;
    logic [MAX_PARTITIONS-1:0] r_busy;

    // result
    logic                r_done;
    logic                r_granted;
    logic [SLOT_W-1:0]   r_chosen;
    logic [PID_W-1:0]    r_echo;

    logic [CNT_W-1:0]     limit;
    logic [SIZE_BITS-1:0] rdata;
    logic [SIZE_BITS-1:0] left;
    logic                 fits;
    logic                 take;
    logic                 ram_we;

    assign limit = (32'(i_piu) > MAX_PARTITIONS) ? CNT_W'(MAX_PARTITIONS) : CNT_W'(i_piu);
    assign o_status.alloc_none = (limit == '0);
    assign o_status.scan_last  = ((CNT_W'(r_k) + CNT_W'(1)) == limit);

    assign ram_we = i_cmd.commit && (r_op == OP_LOAD) && r_load_ok;

    fpfa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (MAX_PARTITIONS)
    ) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (r_req),
        .i_raddr (r_k),
        .o_rdata (rdata)
    );

    assign fits = r_cmp_v && !r_busy[r_cmp_idx] && (rdata >= r_req);
    assign left = rdata - r_req;

    always_comb begin
        take = 1'b0;
        if (fits) begin
            if (!r_found) begin
                take = 1'b1;
            end else if (i_policy == POL_WORST) begin
                take = (left > r_pick_left);
            end else if (i_policy == POL_BEST) begin
                take = (left < r_pick_left);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op      <= i_opcode;
            r_slot    <= IDX_W'(i_slot_index);
            r_load_ok <= (32'(i_slot_index) < MAX_PARTITIONS);
            r_req     <= SIZE_BITS'(i_size_value);
            r_pid     <= ID_BITS'(i_process_id);
            r_k       <= '0;
            r_pick    <= '0;
        end else begin
            if (i_cmd.scan) begin
                r_k <= r_k + IDX_W'(1);
            end
            if (take) begin
                r_pick <= r_cmp_idx;
            end
        end
        if (take) begin
            r_pick_left <= left;
        end
        r_cmp_idx <= r_k;
        if (i_cmd.commit) begin
            r_granted <= (r_op == OP_ALLOC) && r_found;
            r_chosen  <= r_found ? SLOT_W'(r_pick) : '0;
            r_echo    <= (r_op == OP_ALLOC) ? PID_W'(r_pid) : '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_v <= 1'b0;
            r_found <= 1'b0;
            r_busy  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_cmp_v <= i_cmd.scan;
            r_done  <= i_cmd.commit;
            if (i_cmd.latch) begin
                r_found <= 1'b0;
            end else if (take) begin
                r_found <= 1'b1;
            end
            if (i_cmd.commit) begin
                if (r_op == OP_FREE) begin
                    r_busy <= '0;
                end else if (r_op == OP_ALLOC && r_found) begin
                    r_busy[r_pick] <= 1'b1;
                end
            end
        end
    end

    assign o_done        = r_done;
    assign o_granted     = r_granted;
    assign o_chosen_slot = r_chosen;
    assign o_owner_echo  = r_echo;

endmodule

// ===== sv/fixed_partition_fit_allocator.sv =====
// Top level of the fixed-partition fit allocator: config registers and core wiring.
//
// Usage
//   Command channel: an item is a transaction taken on a rising edge with
//   start high and busy low. opcode selects load (write one slot's size),
//   allocate (find a free slot of at least size_value) or free all (clear
//   every busy bit; sizes stay). Unused opcode answers like a load of nothing.
//   Every item gives exactly one result: o_done is high for one cycle with
//   o_granted, o_chosen_slot and o_owner_echo valid. The receiver cannot stall,
//   so the result must be taken in that cycle.
//   Sequence after the start edge: load, free and allocate with no slots in
//   use go straight to the commit state; any other allocate scans the first
//   N = min(partitions_in_use, MAX_PARTITIONS) slots, then drains and commits.
//   The scan reads the size table one slot per cycle through the single RAM
//   read port; one item is handled at a time. busy drops in the o_done cycle,
//   where the next item may be accepted.
//   Config (APB, addr 0 fit_policy, addr 4 partitions_in_use) must be written
//   only while idle; the block does not enforce this. pready is tied high.
//   Reset: policy first fit, 16 slots in use, all slots free. Slot sizes are
//   undefined until loaded; no clearing pass, the block is ready at once.
//   The owner id is reported only through o_owner_echo.
module fixed_partition_fit_allocator #(
    parameter int MAX_PARTITIONS = fpfa_pkg::MAX_PARTITIONS_DEF,
    parameter int SIZE_BITS      = fpfa_pkg::SIZE_BITS_DEF,
    parameter int ID_BITS        = fpfa_pkg::ID_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          start,
    output logic                          busy,
    input  logic [fpfa_pkg::OPCODE_W-1:0] i_opcode,
    input  logic [fpfa_pkg::SLOT_W-1:0]   i_slot_index,
    input  logic [fpfa_pkg::SIZE_W-1:0]   i_size_value,
    input  logic [fpfa_pkg::PID_W-1:0]    i_process_id,
    // result channel
    output logic                          o_done,
    output logic                          o_granted,
    output logic [fpfa_pkg::SLOT_W-1:0]   o_chosen_slot,
    output logic [fpfa_pkg::PID_W-1:0]    o_owner_echo,
    // config port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fpfa_pkg::PADDR_W-1:0]  paddr,
    input  logic [fpfa_pkg::PDATA_W-1:0]  pwdata,
    output logic [fpfa_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import fpfa_pkg::*;

    logic [POLICY_W-1:0] r_policy;
    logic [PIU_W-1:0]    r_piu;
    logic                cfg_wr;
    logic                reg_sel;

    t_ctrl_cmd    cmd;
    t_ctrl_status status;

    // Register select is address bit 2; byte offset bits are ignored.
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POLICY_RESET;
            r_piu    <= PIU_RESET;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_FIT_POLICY: r_policy <= pwdata[POLICY_W-1:0];
                REG_PIU:        r_piu    <= pwdata[PIU_W-1:0];
                default:        r_policy <= r_policy;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_FIT_POLICY: prdata = PDATA_W'(r_policy);
            REG_PIU:        prdata = PDATA_W'(r_piu);
            default:        prdata = '0;
        endcase
    end

    // Sequencer: one item at a time, allocate walks the table slot by slot.
    fpfa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // Datapath: size RAM, busy flags, fit compare and result registers.
    fpfa_dp #(
        .MAX_PARTITIONS (MAX_PARTITIONS),
        .SIZE_BITS      (SIZE_BITS),
        .ID_BITS        (ID_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_policy      (r_policy),
        .i_piu         (r_piu),
        .i_opcode      (i_opcode),
        .i_slot_index  (i_slot_index),
        .i_size_value  (i_size_value),
        .i_process_id  (i_process_id),
        .o_done        (o_done),
        .o_granted     (o_granted),
        .o_chosen_slot (o_chosen_slot),
        .o_owner_echo  (o_owner_echo)
    );

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the fixed-partition fit allocator.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fpfa_pkg::*;

    // Codes the package leaves unnamed: both fall back to defined behavior
    localparam logic [OPCODE_W-1:0] OP_UNUSED  = 2'd3;   // answers like a non-allocate
    localparam logic [POLICY_W-1:0] POL_UNUSED = 2'd3;   // behaves as first fit

    // Register byte addresses on the config port
    localparam logic [PADDR_W-1:0] ADDR_FIT_POLICY = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_PIU        = 3'd4;

    // Cycles without any accepted command, result or register access before the run is declared hung.
    // Slowest legit gap: a random sender idle burst, a full allocate scan and config writes.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 100;

    // Phase plan for the random part: config, item count, idle percentage.
    // Covers both policy extremes, the unused policy, no slots at all, one slot,
    // an oversize slot count that must saturate, and a final stretch with no idling.
    localparam int NUM_PHASES = 10;
    localparam logic [POLICY_W-1:0] PHASE_POLICY [NUM_PHASES] = '{
        POL_WORST, POL_BEST, POL_UNUSED, POL_BEST, POL_WORST,
        POL_FIRST, POL_BEST, POL_WORST, POL_FIRST, POL_BEST
    };
    localparam logic [PIU_W-1:0] PHASE_PIU [NUM_PHASES] = '{
        5'd16, 5'd16, 5'd16, 5'd0, 5'd1, 5'd31, 5'd20, 5'd7, 5'd16, 5'd16
    };
    localparam int PHASE_ITEMS [NUM_PHASES] = '{
        250, 250, 150, 60, 100, 150, 150, 150, 200, 290
    };
    localparam int PHASE_IDLE_PCT [NUM_PHASES] = '{
        20, 0, 35, 15, 25, 10, 30, 0, 20, 0
    };

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [SLOT_W-1:0]   slot;
        logic [SIZE_W-1:0]   size;
        logic [PID_W-1:0]    pid;
    } t_alloc_cmd;

    typedef struct packed {
        logic              granted;
        logic [SLOT_W-1:0] slot;
        logic [PID_W-1:0]  owner;
    } t_grant;

    // ------------------------------------------------------------------
    // DUT connections; every input known from time zero
    // ------------------------------------------------------------------
    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                start        = 1'b0;
    logic                busy;
    logic [OPCODE_W-1:0] i_opcode     = '0;
    logic [SLOT_W-1:0]   i_slot_index = '0;
    logic [SIZE_W-1:0]   i_size_value = '0;
    logic [PID_W-1:0]    i_process_id = '0;
    logic                o_done;
    logic                o_granted;
    logic [SLOT_W-1:0]   o_chosen_slot;
    logic [PID_W-1:0]    o_owner_echo;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [PADDR_W-1:0]  paddr        = '0;
    logic [PDATA_W-1:0]  pwdata       = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    fixed_partition_fit_allocator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_opcode      (i_opcode),
        .i_slot_index  (i_slot_index),
        .i_size_value  (i_size_value),
        .i_process_id  (i_process_id),
        .o_done        (o_done),
        .o_granted     (o_granted),
        .o_chosen_slot (o_chosen_slot),
        .o_owner_echo  (o_owner_echo),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the partition table and config.
    // Owners are not observable at the ports, so only busy bits are kept.
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0]   part_size [MAX_PARTITIONS_DEF];
    bit                  part_busy [MAX_PARTITIONS_DEF];
    logic [POLICY_W-1:0] policy_cfg = POLICY_RESET;
    logic [PIU_W-1:0]    piu_cfg    = PIU_RESET;

    t_alloc_cmd cmd_q[$];     // transactions waiting for the driver
    t_grant     grant_q[$];   // expected results, oldest first

    int err_cnt     = 0;
    int report_cnt  = 0;
    int n_loads     = 0;
    int n_allocs    = 0;
    int n_grants    = 0;
    int n_nofit     = 0;
    int n_frees     = 0;
    int n_ignored   = 0;
    int idle_pct    = 0;

    // Applies one accepted command to the table copy and returns the result
    // the block must report for it.
    function automatic t_grant compute_grant(input t_alloc_cmd c);
        t_grant            g;
        int                lim;
        bit                found;
        int                pick;
        logic [SIZE_W-1:0] pick_left;
        logic [SIZE_W-1:0] left;
        g         = '0;
        found     = 1'b0;
        pick      = 0;
        pick_left = '0;
        case (c.opcode)
            OP_LOAD: begin
                part_size[c.slot] = c.size;
                n_loads++;
            end
            OP_ALLOC: begin
                n_allocs++;
                g.owner = c.pid;   // echoed whether or not it fits
                lim = (piu_cfg > MAX_PARTITIONS_DEF) ? MAX_PARTITIONS_DEF : int'(piu_cfg);
                for (int k = 0; k < lim; k++) begin
                    if (!part_busy[k] && part_size[k] >= c.size) begin
                        left = part_size[k] - c.size;
                        // first fit keeps the first hit; ties keep the lower index
                        if (!found) begin
                            found     = 1'b1;
                            pick      = k;
                            pick_left = left;
                        end else if (policy_cfg == POL_WORST && left > pick_left) begin
                            pick      = k;
                            pick_left = left;
                        end else if (policy_cfg == POL_BEST && left < pick_left) begin
                            pick      = k;
                            pick_left = left;
                        end
                    end
                end
                if (found) begin
                    part_busy[pick] = 1'b1;
                    g.granted       = 1'b1;
                    g.slot          = SLOT_W'(pick);
                    n_grants++;
                end else begin
                    n_nofit++;
                end
            end
            OP_FREE: begin
                // busy bits cleared, sizes kept
                foreach (part_busy[k]) part_busy[k] = 1'b0;
                n_frees++;
            end
            default: n_ignored++;
        endcase
        return g;
    endfunction

    // Sizes lean small so that fits, leftovers and ties collide often;
    // the rest reach the full 16-bit range and its extremes.
    function automatic logic [SIZE_W-1:0] rand_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)      return SIZE_W'($urandom_range(0, 40));
        else if (r < 85) return SIZE_W'($urandom);
        else if (r < 93) return '1;
        else             return '0;
    endfunction

    function automatic t_alloc_cmd rand_cmd();
        t_alloc_cmd  c;
        int unsigned r;
        r        = $urandom_range(0, 99);
        c.slot   = SLOT_W'($urandom_range(0, 15));
        c.size   = rand_size();
        c.pid    = PID_W'($urandom_range(0, 255));
        // mostly allocates against a loaded table, frees keep it from filling up
        if (r < 55)      c.opcode = OP_ALLOC;
        else if (r < 80) c.opcode = OP_LOAD;
        else if (r < 93) c.opcode = OP_FREE;
        else             c.opcode = OP_UNUSED;
        return c;
    endfunction

    function automatic t_alloc_cmd make_cmd(input logic [OPCODE_W-1:0] op,
                                            input logic [SLOT_W-1:0] slot,
                                            input logic [SIZE_W-1:0] size,
                                            input logic [PID_W-1:0] pid);
        t_alloc_cmd c;
        c.opcode = op;
        c.slot   = slot;
        c.size   = size;
        c.pid    = pid;
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents queued commands, holds start while busy, and inserts
    // random idle bursts after a transaction when the phase asks for them.
    // ------------------------------------------------------------------
    t_alloc_cmd cur_cmd;
    int         gap_cnt = 0;

    always @(posedge i_clk) begin : cmd_driver
        bit port_free;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            port_free = !start || !busy;
            if (start && !busy) begin
                grant_q.push_back(compute_grant(cur_cmd));
            end
            if (port_free) begin
                if (gap_cnt > 0) begin
                    gap_cnt--;
                    start <= 1'b0;
                end else if (cmd_q.size() != 0) begin
                    cur_cmd = cmd_q.pop_front();
                    i_opcode     <= cur_cmd.opcode;
                    i_slot_index <= cur_cmd.slot;
                    i_size_value <= cur_cmd.size;
                    i_process_id <= cur_cmd.pid;
                    start        <= 1'b1;
                    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
                        gap_cnt = $urandom_range(1, 12);
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: o_done is a one-cycle strobe, every strobe must match the
    // oldest expectation field by field.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_grant want;
        bit     bad;
        if (i_rst_n && o_done) begin
            if (grant_q.size() == 0) begin
                err_cnt++;
                if (report_cnt < MAX_REPORTS) begin
                    $display("%0t: result with no transaction pending:", $time);
                    $display("    granted %0d slot %0d owner %0d",
                             o_granted, o_chosen_slot, o_owner_echo);
                end
                report_cnt++;
            end else begin
                want = grant_q.pop_front();
                bad  = 1'b0;
                if (report_cnt < MAX_REPORTS) begin
                    if (o_granted !== want.granted)
                        $display("%0t: granted expected %0d actual %0d",
                                 $time, want.granted, o_granted);
                    if (o_chosen_slot !== want.slot)
                        $display("%0t: chosen_slot expected %0d actual %0d",
                                 $time, want.slot, o_chosen_slot);
                    if (o_owner_echo !== want.owner)
                        $display("%0t: owner_echo expected %0d actual %0d",
                                 $time, want.owner, o_owner_echo);
                end
                bad = (o_granted !== want.granted) || (o_chosen_slot !== want.slot) ||
                      (o_owner_echo !== want.owner);
                if (bad) begin
                    err_cnt++;
                    report_cnt++;
                end
            end
        end
    end

    // Watchdog: any accepted command, result or register access restarts it
    int idle_cycles = 0;

    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            if ((start && !busy) || o_done || (psel && penable)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("fixed_partition_fit_allocator test failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Config port: write, then read back. Only called while the block idles.
    // ------------------------------------------------------------------
    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        logic [PDATA_W-1:0] want;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        // write lands on this edge
        if (addr == ADDR_FIT_POLICY) policy_cfg = data[POLICY_W-1:0];
        else                         piu_cfg    = data[PIU_W-1:0];
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        want = (addr == ADDR_FIT_POLICY) ? PDATA_W'(policy_cfg) : PDATA_W'(piu_cfg);
        if (addr == ADDR_FIT_POLICY ? (prdata[POLICY_W-1:0] !== policy_cfg)
                                    : (prdata[PIU_W-1:0] !== piu_cfg)) begin
            err_cnt++;
            $display("%0t: register at %0d read back expected %0d actual %0d",
                     $time, addr, want, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Sender hold-off: nothing queued, nothing on the port, nothing owed
    task automatic wait_drained();
        while (cmd_q.size() != 0 || start || gap_cnt != 0 || grant_q.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [SIZE_W-1:0] load_sizes [MAX_PARTITIONS_DEF];
        load_sizes = '{16'd0, 16'hFFFF, 16'd300, 16'd40, 16'd40, 16'd1000, 16'd5, 16'd40,
                       16'hAAAA, 16'h5555, 16'd12, 16'd7, 16'd40, 16'd2, 16'd100, 16'hFFFE};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at reset config (first fit, all 16 slots).
        // Every slot gets a size before any allocate can read it.
        foreach (load_sizes[k])
            cmd_q.push_back(make_cmd(OP_LOAD, SLOT_W'(k), load_sizes[k], PID_W'(k)));
        cmd_q.push_back(make_cmd(OP_ALLOC, 4'd0, 16'd0, 8'd0));       // zero request, zero slot
        cmd_q.push_back(make_cmd(OP_ALLOC, 4'd0, 16'hFFFF, 8'hFF));   // only the full slot fits
        cmd_q.push_back(make_cmd(OP_ALLOC, 4'd0, 16'hFFFF, 8'hA5));   // no fit, pid still echoed
        cmd_q.push_back(make_cmd(OP_UNUSED, 4'hF, 16'hFFFF, 8'hFF));  // unused opcode
        cmd_q.push_back(make_cmd(OP_LOAD, 4'd1, 16'hFFFF, 8'h5A));    // load onto a busy slot
        cmd_q.push_back(make_cmd(OP_ALLOC, 4'd0, 16'd40, 8'h5A));
        cmd_q.push_back(make_cmd(OP_FREE, 4'd0, 16'd0, 8'd0));
        cmd_q.push_back(make_cmd(OP_ALLOC, 4'd0, 16'hFFFF, 8'h7F));   // slot freed again
        cmd_q.push_back(make_cmd(OP_ALLOC, 4'd0, 16'd1, 8'd1));

        // Random phases; each config change waits for the block to drain
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            repeat (2) @(posedge i_clk);
            reg_write(ADDR_FIT_POLICY, PDATA_W'(PHASE_POLICY[p]));
            reg_write(ADDR_PIU, PDATA_W'(PHASE_PIU[p]));
            idle_pct = PHASE_IDLE_PCT[p];
            for (int n = 0; n < PHASE_ITEMS[p]; n++)
                cmd_q.push_back(rand_cmd());
        end

        wait_drained();
        repeat (25) @(posedge i_clk);

        if (grant_q.size() != 0) begin
            err_cnt++;
            $display("%0t: %0d expected results never arrived", $time, grant_q.size());
        end
        $display("Covered %0d loads, %0d allocates (%0d granted, %0d without fit),",
                 n_loads, n_allocs, n_grants, n_nofit);
        $display("%0d frees, %0d unused opcodes over %0d register settings; %0d mismatches",
                 n_frees, n_ignored, NUM_PHASES + 1, err_cnt);
        if (err_cnt == 0) begin
            $display("fixed_partition_fit_allocator test passed");
        end else begin
            $display("fixed_partition_fit_allocator test failed");
        end
        $finish;
    end

endmodule
